>>> hw/rtl/address_range_region_table_defines.svh
// assertion macros for the region table
`ifndef ADDRESS_RANGE_REGION_TABLE_DEFINES_SVH
`define ADDRESS_RANGE_REGION_TABLE_DEFINES_SVH
`define ARRT_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("%m: check failed");
`define ARRT_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("%m: check failed");
`endif

>>> hw/rtl/arrt_pkg.sv
// shared types and constants of the region table
package arrt_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_SEAL = 2'd1,
        CMD_UNREGISTER = 2'd2,
        CMD_PROBE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_DUP = 3'd1,
        ST_BOUNDS = 3'd2,
        ST_FULL = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_SEALED = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic [63:0] key;
        logic [63:0] rbegin;
        logic [63:0] rend;
        logic [63:0] addr;
        logic        bounds_bad;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        is_static;
        logic [4:0]  dyn_count;
        logic [63:0] main_low;
        logic [63:0] main_high;
    } rsp_t;
endpackage

>>> hw/rtl/arrt_front.sv
// input stage: takes requests, checks bounds and queues them
module arrt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  arrt_pkg::req_t    in_req,
    output logic              q_valid,
    input  logic              q_ready,
    output arrt_pkg::req_t    q_req
);
    arrt_pkg::req_t mem_reg [arrt_pkg::QUEUE_DEPTH];
    logic [arrt_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [arrt_pkg::QCNT_W-1:0] cnt_reg;
    arrt_pkg::req_t cls;
    logic push, pop;

    always_comb begin
        cls = in_req;
        cls.bounds_bad = in_req.rbegin > in_req.rend;
    end

    assign in_ready = cnt_reg != arrt_pkg::QCNT_W'(arrt_pkg::QUEUE_DEPTH);
    assign push = in_valid && in_ready;
    assign q_valid = cnt_reg != '0;
    assign pop = q_valid && q_ready;
    assign q_req = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + arrt_pkg::QCNT_W'(push) - arrt_pkg::QCNT_W'(pop);
        end
    end
endmodule

>>> hw/rtl/arrt_back.sv
// execution stage: scans the table one slot per cycle
module arrt_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  arrt_pkg::req_t    q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output arrt_pkg::rsp_t    out_rsp
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_APPLY = 5'b00100,
        S_HULL = 5'b01000,
        S_OUT = 5'b10000
    } state_t;

    localparam int N = arrt_pkg::TABLE_ENTRIES;

    state_t state_reg, state_next;
    logic [63:0] key_reg [N];
    logic [63:0] beg_reg [N];
    logic [63:0] end_reg [N];
    logic [N-1:0] valid_reg, main_reg;
    logic sealed_reg;
    logic [63:0] lo_reg, hi_reg, hlo_reg, hhi_reg;
    logic [arrt_pkg::CNT_W-1:0] dyn_reg;
    arrt_pkg::req_t req_reg;
    logic [arrt_pkg::CNT_W-1:0] idx_reg;
    logic found_reg, free_found_reg, hit_reg;
    logic [arrt_pkg::IDX_W-1:0] found_idx_reg, free_idx_reg;
    arrt_pkg::rsp_t rsp_reg;
    logic [arrt_pkg::IDX_W-1:0] i;
    logic last;

    assign i = idx_reg[arrt_pkg::IDX_W-1:0];
    assign last = idx_reg == arrt_pkg::CNT_W'(N - 1);
    assign q_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_rsp = rsp_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = S_SCAN;
            S_SCAN: if (last) state_next = S_APPLY;
            S_APPLY: state_next = S_OUT;
            S_HULL: if (last) state_next = S_OUT;
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_APPLY && ((req_reg.command == arrt_pkg::CMD_SEAL && !sealed_reg)
            || (req_reg.command == arrt_pkg::CMD_UNREGISTER && found_reg
                && main_reg[found_idx_reg])))
            state_next = S_HULL;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && q_valid) req_reg <= q_req;
        if (state_reg == S_APPLY && req_reg.command == arrt_pkg::CMD_REGISTER
            && !found_reg && !req_reg.bounds_bad && free_found_reg) begin
            key_reg[free_idx_reg] <= req_reg.key;
            beg_reg[free_idx_reg] <= req_reg.rbegin;
            end_reg[free_idx_reg] <= req_reg.rend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            main_reg <= '0;
            sealed_reg <= 1'b0;
            lo_reg <= '0;
            hi_reg <= '0;
            dyn_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg <= '0;
            hlo_reg <= '0;
            hhi_reg <= '0;
            rsp_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: begin
                    idx_reg <= '0;
                    found_reg <= 1'b0;
                    free_found_reg <= 1'b0;
                    hit_reg <= q_req.addr >= lo_reg && q_req.addr < hi_reg;
                end
                S_SCAN: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (valid_reg[i] && key_reg[i] == req_reg.key && !found_reg) begin
                        found_reg <= 1'b1;
                        found_idx_reg <= i;
                    end
                    if (!valid_reg[i] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg <= i;
                    end
                    if (valid_reg[i] && !main_reg[i] && req_reg.addr >= beg_reg[i]
                        && req_reg.addr < end_reg[i])
                        hit_reg <= 1'b1;
                end
                S_APPLY: begin
                    idx_reg <= '0;
                    hlo_reg <= '1;
                    hhi_reg <= '0;
                    case (req_reg.command)
                        arrt_pkg::CMD_REGISTER: begin
                            rsp_reg.is_static <= 1'b0;
                            if (found_reg) rsp_reg.status <= arrt_pkg::ST_DUP;
                            else if (req_reg.bounds_bad)
                                rsp_reg.status <= arrt_pkg::ST_BOUNDS;
                            else if (!free_found_reg)
                                rsp_reg.status <= arrt_pkg::ST_FULL;
                            else begin
                                rsp_reg.status <= arrt_pkg::ST_OK;
                                valid_reg[free_idx_reg] <= 1'b1;
                                main_reg[free_idx_reg] <= 1'b0;
                                dyn_reg <= dyn_reg + 1'b1;
                            end
                        end
                        arrt_pkg::CMD_SEAL: begin
                            rsp_reg.is_static <= 1'b0;
                            if (sealed_reg) rsp_reg.status <= arrt_pkg::ST_SEALED;
                            else begin
                                rsp_reg.status <= arrt_pkg::ST_OK;
                                sealed_reg <= 1'b1;
                                main_reg <= valid_reg;
                                dyn_reg <= '0;
                            end
                        end
                        arrt_pkg::CMD_UNREGISTER: begin
                            rsp_reg.is_static <= 1'b0;
                            if (!found_reg) rsp_reg.status <= arrt_pkg::ST_UNKNOWN;
                            else begin
                                rsp_reg.status <= arrt_pkg::ST_OK;
                                valid_reg[found_idx_reg] <= 1'b0;
                                main_reg[found_idx_reg] <= 1'b0;
                                if (!main_reg[found_idx_reg]) dyn_reg <= dyn_reg - 1'b1;
                            end
                        end
                        default: begin
                            rsp_reg.status <= arrt_pkg::ST_OK;
                            rsp_reg.is_static <= hit_reg;
                        end
                    endcase
                end
                S_HULL: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (valid_reg[i] && main_reg[i] && beg_reg[i] != end_reg[i]) begin
                        if (beg_reg[i] < hlo_reg) hlo_reg <= beg_reg[i];
                        if (end_reg[i] > hhi_reg) hhi_reg <= end_reg[i];
                    end
                    if (last) begin
                        lo_reg <= (valid_reg[i] && main_reg[i] && beg_reg[i] != end_reg[i]
                                   && beg_reg[i] < hlo_reg) ? beg_reg[i] : hlo_reg;
                        hi_reg <= (valid_reg[i] && main_reg[i] && beg_reg[i] != end_reg[i]
                                   && end_reg[i] > hhi_reg) ? end_reg[i] : hhi_reg;
                    end
                end
                default: ;
            endcase
            if (state_reg == S_APPLY && state_next == S_OUT) begin
                rsp_reg.main_low <= lo_reg;
                rsp_reg.main_high <= hi_reg;
                if (req_reg.command == arrt_pkg::CMD_REGISTER && !found_reg
                    && !req_reg.bounds_bad && free_found_reg)
                    rsp_reg.dyn_count <= 5'(dyn_reg + 1'b1);
                else if (req_reg.command == arrt_pkg::CMD_UNREGISTER && found_reg)
                    rsp_reg.dyn_count <= 5'(dyn_reg - 1'b1);
                else
                    rsp_reg.dyn_count <= 5'(dyn_reg);
            end
            if (state_reg == S_HULL && last) begin
                rsp_reg.dyn_count <= 5'(dyn_reg);
                rsp_reg.main_low <= (valid_reg[i] && main_reg[i] && beg_reg[i] != end_reg[i]
                                     && beg_reg[i] < hlo_reg) ? beg_reg[i] : hlo_reg;
                rsp_reg.main_high <= (valid_reg[i] && main_reg[i] && beg_reg[i] != end_reg[i]
                                      && end_reg[i] > hhi_reg) ? end_reg[i] : hhi_reg;
            end
        end
    end
endmodule

>>> hw/rtl/address_range_region_table.sv
// top level of the address region table
// Each request is queued by the input stage and then run by one sequencer that
// scans the 16-slot table one slot per cycle: a request passes from leaving the
// queue to its response through the load, scan, apply and output states, and
// a first seal or a removal of a main region adds a hull scan of the table.
// The two-entry queue takes new requests while one runs or waits at the output.
module address_range_region_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], region_key[65:2], region_begin[129:66], region_end[193:130],
    // probe_addr[257:194], zero fill
    input  logic [263:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], is_static[3], dynamic_count[8:4], main_low[72:9],
    // main_high[136:73], zero fill
    output logic [143:0] m_tdata
);
    arrt_pkg::req_t in_req, q_req;
    arrt_pkg::rsp_t rsp;
    logic q_valid, q_ready;

    always_comb begin
        in_req.command = arrt_pkg::cmd_t'(s_tdata[1:0]);
        in_req.key = s_tdata[65:2];
        in_req.rbegin = s_tdata[129:66];
        in_req.rend = s_tdata[193:130];
        in_req.addr = s_tdata[257:194];
        in_req.bounds_bad = 1'b0;
    end

    arrt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    arrt_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_rsp(rsp)
    );

    assign m_tdata = {7'd0, rsp.main_high, rsp.main_low, rsp.dyn_count,
                      rsp.is_static, rsp.status};
endmodule

>>> hw/rtl/arrt_checker.sv
// port checks of the region table
`include "address_range_region_table_defines.svh"
module arrt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [263:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);
    logic unused;
    assign unused = s_tvalid ^ s_tready ^ (^s_tdata);

    `ARRT_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ARRT_ASSERT_IMPL(a_status, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd5)
    `ARRT_ASSERT_IMPL(a_static, aclk, aresetn, m_tvalid && m_tdata[3], m_tdata[2:0] == 3'd0)
    `ARRT_ASSERT_IMPL(a_count, aclk, aresetn, m_tvalid, m_tdata[8:4] <= 5'd16)
endmodule

bind address_range_region_table arrt_checker u_checker (.*);

>>> tb/address_range_region_table_tb.sv
// self-checking testbench for the address region table
module address_range_region_table_tb;
    typedef struct {
        arrt_pkg::cmd_t command;
        logic [63:0]    key;
        logic [63:0]    rbegin;
        logic [63:0]    rend;
        logic [63:0]    addr;
    } request_t;

    typedef struct {
        arrt_pkg::status_t status;
        logic              is_static;
        logic [4:0]        dyn_count;
        logic [63:0]       main_low;
        logic [63:0]       main_high;
    } answer_t;

    localparam int STALL_LIMIT = 4000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [263:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;

    // region table copy
    logic [63:0] tbl_key [arrt_pkg::TABLE_ENTRIES];
    logic [63:0] tbl_begin [arrt_pkg::TABLE_ENTRIES];
    logic [63:0] tbl_end [arrt_pkg::TABLE_ENTRIES];
    logic        tbl_valid [arrt_pkg::TABLE_ENTRIES];
    logic        tbl_main [arrt_pkg::TABLE_ENTRIES];
    logic        sealed;
    logic [63:0] hull_lo;
    logic [63:0] hull_hi;
    logic [4:0]  dyn_regions;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    logic [63:0] key_pool[$];
    int       error_count;
    int       idle_cycles;
    int       hold_off;
    bit       quiet_phase;
    bit       sender_pause;
    logic     s_tready_seen;

    address_range_region_table u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic clear_table();
        for (int i = 0; i < arrt_pkg::TABLE_ENTRIES; i++) begin
            tbl_key[i] = '0;
            tbl_begin[i] = '0;
            tbl_end[i] = '0;
            tbl_valid[i] = 1'b0;
            tbl_main[i] = 1'b0;
        end
        sealed = 1'b0;
        hull_lo = '0;
        hull_hi = '0;
        dyn_regions = '0;
    endtask

    function automatic void rebuild_hull();
        hull_lo = '1;
        hull_hi = '0;
        for (int i = 0; i < arrt_pkg::TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_main[i] && tbl_begin[i] != tbl_end[i]) begin
                if (tbl_begin[i] < hull_lo) hull_lo = tbl_begin[i];
                if (tbl_end[i] > hull_hi) hull_hi = tbl_end[i];
            end
        end
    endfunction

    function automatic int slot_of_key(logic [63:0] k);
        for (int i = 0; i < arrt_pkg::TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int slot;
        a.status = arrt_pkg::ST_OK;
        a.is_static = 1'b0;
        case (r.command)
            arrt_pkg::CMD_REGISTER: begin
                slot = -1;
                if (slot_of_key(r.key) >= 0) a.status = arrt_pkg::ST_DUP;
                else if (r.rbegin > r.rend) a.status = arrt_pkg::ST_BOUNDS;
                else begin
                    for (int i = arrt_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
                        if (!tbl_valid[i]) slot = i;
                    if (slot < 0) a.status = arrt_pkg::ST_FULL;
                    else begin
                        tbl_key[slot] = r.key;
                        tbl_begin[slot] = r.rbegin;
                        tbl_end[slot] = r.rend;
                        tbl_valid[slot] = 1'b1;
                        tbl_main[slot] = 1'b0;
                        dyn_regions = dyn_regions + 5'd1;
                    end
                end
            end
            arrt_pkg::CMD_SEAL: begin
                if (sealed) a.status = arrt_pkg::ST_SEALED;
                else begin
                    sealed = 1'b1;
                    for (int i = 0; i < arrt_pkg::TABLE_ENTRIES; i++)
                        if (tbl_valid[i]) tbl_main[i] = 1'b1;
                    dyn_regions = '0;
                    rebuild_hull();
                end
            end
            arrt_pkg::CMD_UNREGISTER: begin
                slot = slot_of_key(r.key);
                if (slot < 0) a.status = arrt_pkg::ST_UNKNOWN;
                else begin
                    tbl_valid[slot] = 1'b0;
                    if (tbl_main[slot]) begin
                        tbl_main[slot] = 1'b0;
                        rebuild_hull();
                    end else begin
                        dyn_regions = dyn_regions - 5'd1;
                    end
                end
            end
            default: begin
                if (r.addr >= hull_lo && r.addr < hull_hi) a.is_static = 1'b1;
                for (int i = 0; i < arrt_pkg::TABLE_ENTRIES; i++)
                    if (tbl_valid[i] && !tbl_main[i] && r.addr >= tbl_begin[i]
                            && r.addr < tbl_end[i])
                        a.is_static = 1'b1;
            end
        endcase
        a.dyn_count = dyn_regions;
        a.main_low = hull_lo;
        a.main_high = hull_hi;
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // addresses mostly clustered in a small window so regions and probes overlap, some at the extremes or random
    function automatic logic [63:0] rand_addr();
        case ($urandom_range(0, 9))
            0: return rand64();
            1: return '1 - 64'($urandom_range(0, 4));
            2: return 64'($urandom_range(0, 4));
            default: return 64'h1000 + 64'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return rand64();
    endfunction

    function automatic request_t decode_request(logic [263:0] d);
        request_t r;
        r.command = arrt_pkg::cmd_t'(d[1:0]);
        r.key = d[65:2];
        r.rbegin = d[129:66];
        r.rend = d[193:130];
        r.addr = d[257:194];
        return r;
    endfunction

    task automatic push_request(arrt_pkg::cmd_t c, logic [63:0] k, logic [63:0] b,
                                logic [63:0] e, logic [63:0] p);
        request_t r;
        r.command = c;
        r.key = k;
        r.rbegin = b;
        r.rend = e;
        r.addr = p;
        pending_requests.push_back(r);
        if (c == arrt_pkg::CMD_REGISTER && key_pool.size() < 40) key_pool.push_back(k);
    endtask

    task automatic push_random(int weight_seal);
        logic [63:0] b;
        logic [63:0] e;
        int pick;
        pick = int'($urandom_range(0, 99));
        b = rand_addr();
        e = ($urandom_range(0, 7) == 0) ? rand_addr() : b + 64'($urandom_range(0, 300));
        if (pick < weight_seal)
            push_request(arrt_pkg::CMD_SEAL, rand64(), rand64(), rand64(), rand64());
        else if (pick < 40)
            push_request(arrt_pkg::CMD_REGISTER, pick_key(), b, e, rand64());
        else if (pick < 60)
            push_request(arrt_pkg::CMD_UNREGISTER, pick_key(), rand64(), rand64(), rand64());
        else
            push_request(arrt_pkg::CMD_PROBE, rand64(), rand64(), rand64(), rand_addr());
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready_seen) begin
            if (pending_requests.size() > 0 && !sender_pause
                    && (quiet_phase || $urandom_range(0, 99) >= 9)) begin
                request_t r;
                r = pending_requests.pop_front();
                s_tdata <= {6'b0, r.addr, r.rend, r.rbegin, r.key, r.command};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // accepted-at-edge flag for the driver, and expected answers of accepted requests
    always @(posedge aclk) begin
        s_tready_seen <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_answers.push_back(apply_request(decode_request(s_tdata)));
    end

    // receiver ready
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else m_tready <= quiet_phase || $urandom_range(0, 99) >= 9;
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            answer_t want;
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected response", m_tdata[63:0], '0);
            end else begin
                want = expected_answers.pop_front();
                if (m_tdata[2:0] != want.status)
                    report_mismatch("status", 64'(m_tdata[2:0]), 64'(want.status));
                if (m_tdata[3] != want.is_static)
                    report_mismatch("is_static", 64'(m_tdata[3]), 64'(want.is_static));
                if (m_tdata[8:4] != want.dyn_count)
                    report_mismatch("dynamic_count", 64'(m_tdata[8:4]), 64'(want.dyn_count));
                if (m_tdata[72:9] != want.main_low)
                    report_mismatch("main_low", m_tdata[72:9], want.main_low);
                if (m_tdata[136:73] != want.main_high)
                    report_mismatch("main_high", m_tdata[136:73], want.main_high);
                if (m_tdata[143:137] != '0)
                    report_mismatch("fill", 64'(m_tdata[143:137]), '0);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        s_tready_seen = 1'b0;
        idle_cycles = 0;
        hold_off = 0;
        error_count = 0;
        quiet_phase = 1'b0;
        sender_pause = 1'b0;
        clear_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: pre-seal probe, bounds, extremes, duplicate, empty region, full table, seal, removal
        push_request(arrt_pkg::CMD_PROBE, '0, '0, '0, '0);
        push_request(arrt_pkg::CMD_REGISTER, '0, 64'd10, 64'd9, '0);
        push_request(arrt_pkg::CMD_REGISTER, '0, '0, '1, '0);
        push_request(arrt_pkg::CMD_REGISTER, '0, 64'd5, 64'd6, '1);
        push_request(arrt_pkg::CMD_REGISTER, '1, 64'd500, 64'd500, '1);
        push_request(arrt_pkg::CMD_PROBE, '1, '1, '1, '1);
        push_request(arrt_pkg::CMD_PROBE, '0, '0, '0, 64'd500);
        push_request(arrt_pkg::CMD_UNREGISTER, 64'h1234, '0, '0, '0);
        push_request(arrt_pkg::CMD_UNREGISTER, '0, '0, '0, '0);
        for (int i = 0; i < arrt_pkg::TABLE_ENTRIES; i++)
            push_request(arrt_pkg::CMD_REGISTER, 64'(i + 100), 64'(i * 16),
                         64'(i * 16 + 8), '0);
        push_request(arrt_pkg::CMD_REGISTER, 64'd999, 64'd1, 64'd2, '0);
        push_request(arrt_pkg::CMD_SEAL, '0, '0, '0, '0);
        push_request(arrt_pkg::CMD_SEAL, '1, '1, '1, '1);
        push_request(arrt_pkg::CMD_PROBE, '0, '0, '0, 64'd250);
        push_request(arrt_pkg::CMD_UNREGISTER, 64'd100, '0, '0, '0);
        push_request(arrt_pkg::CMD_UNREGISTER, '1, '0, '0, '0);

        // random phases of mixed requests
        for (int blk = 0; blk < 17; blk++) begin
            quiet_phase = (blk == 3);
            if (blk == 5) hold_off = 600;
            for (int n = 0; n < 100; n++) push_random(blk == 0 ? 3 : 1);
            if (blk == 8) begin
                while (pending_requests.size() != 0) @(posedge aclk);
                sender_pause = 1'b1;
                while (expected_answers.size() != 0 || s_tvalid) @(posedge aclk);
                repeat (40) @(posedge aclk);
                sender_pause = 1'b0;
            end
            while (pending_requests.size() > 20) @(posedge aclk);
        end

        while (pending_requests.size() != 0) @(posedge aclk);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        while (expected_answers.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/arrt_pkg.sv
hw/rtl/arrt_front.sv
hw/rtl/arrt_back.sv
hw/rtl/address_range_region_table.sv
hw/rtl/arrt_checker.sv
tb/address_range_region_table_tb.sv
